// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file bbcg_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/bbcg_pkg.sv =====
`default_nettype none
package bbcg_pkg;

    localparam int SAMPLES_DEF = 128;
    localparam int PRESS_W     = 23;
    localparam int OUT_W       = 24;
    localparam int STEP_W      = 16;
    localparam logic [STEP_W-1:0] GATE_STEP_RST = 16'd1037;

    // Result phase codes
    localparam logic [1:0] PH_GATE    = 2'd0;
    localparam logic [1:0] PH_COLLECT = 2'd1;
    localparam logic [1:0] PH_ACCEPT  = 2'd2;
    localparam logic [1:0] PH_REJECT  = 2'd3;

    typedef enum logic {
        T_IDLE,
        T_CALIB
    } top_state_t;

    typedef enum logic [2:0] {
        E_IDLE,
        E_DIV,
        E_LOAD,
        E_CAND,
        E_SCAN,
        E_FENCE
    } eng_state_t;

    // Calibration engine status toward the top level
    typedef struct packed {
        logic               done;
        logic               clean;
        logic [PRESS_W-1:0] mean;
    } cal_status_t;

endpackage
`default_nettype wire

// ===== design/bbcg_ram.sv =====
`default_nettype none
module bbcg_ram #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== design/bbcg_calib.sv =====
`default_nettype none
module bbcg_calib #(
    parameter int SAMPLES = bbcg_pkg::SAMPLES_DEF
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       start,
    input  wire logic [bbcg_pkg::PRESS_W+$clog2(SAMPLES)-1:0] sum,
    input  wire logic [bbcg_pkg::PRESS_W-1:0]               min_val,
    input  wire logic [bbcg_pkg::PRESS_W-1:0]               max_val,
    output logic      [$clog2(SAMPLES)-1:0]                 raddr,
    input  wire logic [bbcg_pkg::PRESS_W-1:0]               rdata,
    output bbcg_pkg::cal_status_t                           status
);

    localparam int PW    = bbcg_pkg::PRESS_W;
    localparam int IW    = $clog2(SAMPLES);
    localparam int CW    = $clog2(SAMPLES + 1);
    localparam int SUM_W = PW + IW;
    localparam int FW    = PW + 4;

    // Reciprocal of SAMPLES: exact mean for every sum below 2^31
    localparam int RK = 40;
    localparam int RW = 38;
    localparam int RH = RW / 2;
    localparam int AW = SUM_W + RW;
    localparam logic [RW-1:0] RECIP = RW'((64'd1 << RK) / SAMPLES + 1);

    localparam logic [CW-1:0] K1A = CW'(SAMPLES / 4 - 1);
    localparam logic [CW-1:0] K1B = CW'(SAMPLES / 4);
    localparam logic [CW-1:0] K3A = CW'((3 * SAMPLES) / 4 - 1);
    localparam logic [CW-1:0] K3B = CW'((3 * SAMPLES) / 4);
    localparam logic [IW-1:0] LAST_IDX = IW'(SAMPLES - 1);

    bbcg_pkg::eng_state_t state_reg, state_next;

    logic [AW-1:0]    acc_reg;
    logic [IW-1:0]    i_reg;
    logic [IW-1:0]    j_reg;
    logic [PW-1:0]    cand_reg;
    logic [CW-1:0]    lt_reg;
    logic [CW-1:0]    le_reg;
    logic [PW-1:0]    q1a_reg, q1b_reg, q3a_reg, q3b_reg;

    logic [RH-1:0]       mul_b;
    logic [SUM_W+RH-1:0] prod;
    logic [CW-1:0]    lt_next, le_next;
    logic             scan_last;

    logic signed [FW-1:0] q1x2, q3x2, two_iqr, upper, lower, mx2, mn2;

    // Mean: low half of the reciprocal at start, high half in the following E_DIV state
    assign mul_b = (state_reg == bbcg_pkg::E_DIV) ? RECIP[RW-1:RH] : RECIP[RH-1:0];
    assign prod  = {{RH{1'b0}}, sum} * {{SUM_W{1'b0}}, mul_b};

    // Rank counters for the current candidate
    assign lt_next   = lt_reg + CW'(rdata < cand_reg);
    assign le_next   = le_reg + CW'(rdata <= cand_reg);
    assign scan_last = (j_reg == LAST_IDX);

    // Fences at twice scale
    assign q1x2    = $signed({4'b0, q1a_reg}) + $signed({4'b0, q1b_reg});
    assign q3x2    = $signed({4'b0, q3a_reg}) + $signed({4'b0, q3b_reg});
    assign two_iqr = (q3x2 - q1x2) <<< 1;
    assign upper   = q3x2 + two_iqr;
    assign lower   = q1x2 - two_iqr;
    assign mx2     = $signed({3'b0, max_val, 1'b0});
    assign mn2     = $signed({3'b0, min_val, 1'b0});

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bbcg_pkg::E_IDLE:  if (start) state_next = bbcg_pkg::E_DIV;
            bbcg_pkg::E_DIV:   state_next = bbcg_pkg::E_LOAD;
            bbcg_pkg::E_LOAD:  state_next = bbcg_pkg::E_CAND;
            bbcg_pkg::E_CAND:  state_next = bbcg_pkg::E_SCAN;
            bbcg_pkg::E_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = (i_reg == LAST_IDX) ? bbcg_pkg::E_FENCE : bbcg_pkg::E_LOAD;
                end
            end
            bbcg_pkg::E_FENCE: state_next = bbcg_pkg::E_IDLE;
            default:           state_next = bbcg_pkg::E_IDLE;
        endcase
    end

    // Outputs: read address and status
    always_comb
    begin
        raddr        = '0;
        status.done  = 1'b0;
        status.clean = (mx2 <= upper) && (mn2 >= lower);
        status.mean  = acc_reg[RK +: PW];
        unique case (state_reg)
            bbcg_pkg::E_LOAD:  raddr = i_reg;
            bbcg_pkg::E_SCAN:  raddr = j_reg + 1'b1;
            bbcg_pkg::E_FENCE: status.done = 1'b1;
            default:           raddr = '0;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bbcg_pkg::E_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            bbcg_pkg::E_IDLE:
            begin
                acc_reg <= {{(RW-RH){1'b0}}, prod};
                i_reg   <= '0;
            end
            bbcg_pkg::E_DIV:
            begin
                acc_reg <= acc_reg + {prod, {RH{1'b0}}};
            end
            bbcg_pkg::E_CAND:
            begin
                cand_reg <= rdata;
                lt_reg   <= '0;
                le_reg   <= '0;
                j_reg    <= '0;
            end
            bbcg_pkg::E_SCAN:
            begin
                lt_reg <= lt_next;
                le_reg <= le_next;
                j_reg  <= j_reg + 1'b1;
                if (scan_last)
                begin
                    // Capture the candidate for each rank it covers
                    if (lt_next <= K1A && K1A < le_next) q1a_reg <= cand_reg;
                    if (lt_next <= K1B && K1B < le_next) q1b_reg <= cand_reg;
                    if (lt_next <= K3A && K3A < le_next) q3a_reg <= cand_reg;
                    if (lt_next <= K3B && K3B < le_next) q3b_reg <= cand_reg;
                    i_reg <= i_reg + 1'b1;
                end
            end
            default:
            begin
                cand_reg <= cand_reg;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/baro_baseline_calibrate_gate.sv =====
// Barometer baseline gate. Each input beat yields one output beat. A gating or
// collecting beat loads the result register at its accepting edge and moves to
// the output register when that is empty or being read; no new input beat is
// taken while the result register is full. The beat that ends a collection runs
// the calibration engine on the sample memory (one read port): a reciprocal
// multiply in two halves for the mean (the start cycle and E_DIV), then a rank
// count that reads every stored sample once per stored sample (E_LOAD, E_CAND
// and E_SCAN for each candidate), then E_FENCE for the fences. Its result
// register loads when the engine reports done, and the input stays stalled
// until then. One more input beat may be taken while a result waits at the
// output.
`default_nettype none
module baro_baseline_calibrate_gate #(
    parameter int SAMPLES = bbcg_pkg::SAMPLES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration: gate_step
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // [22:0] pressure, [23] zero
    input  wire logic [0:0]  s_axis_tuser,  // [0] armed
    // Output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // [23:0] relative_pressure
    output logic [1:0]       m_axis_tuser   // [1:0] phase
);

    localparam int PW    = bbcg_pkg::PRESS_W;
    localparam int OW    = bbcg_pkg::OUT_W;
    localparam int IW    = $clog2(SAMPLES);
    localparam int CW    = $clog2(SAMPLES + 1);
    localparam int SUM_W = PW + IW;
    localparam int GW    = OW + 2;
    localparam logic [CW-1:0]        SAMPLES_C = CW'(SAMPLES);
    localparam logic signed [GW-1:0] OUT_MAX   = GW'(8388607);
    localparam logic signed [GW-1:0] OUT_MIN   = -GW'(8388608);

    bbcg_pkg::top_state_t state_reg, state_next;

    logic [15:0]       gate_step_reg;
    logic              armed_seen_reg;
    logic              calibrated_reg;
    logic [CW-1:0]     count_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [PW-1:0]     baseline_reg;
    logic [OW-1:0]     last_reg;
    logic [PW-1:0]     min_reg, max_reg;
    logic              res_valid_reg;
    logic [OW-1:0]     res_data_reg;
    logic [1:0]        res_phase_reg;
    logic              out_valid_reg;
    logic [OW-1:0]     out_data_reg;
    logic [1:0]        out_phase_reg;

    logic              in_fire;
    logic [PW-1:0]     pressure;
    logic              armed_now;
    logic              is_collect;
    logic              is_finish;
    logic              cal_start;
    logic              out_load;
    logic signed [GW-1:0] raw, lo, hi, clamped;
    logic [OW-1:0]     gated;

    logic [IW-1:0]     ram_raddr;
    logic [PW-1:0]     ram_rdata;
    bbcg_pkg::cal_status_t cal_status;

    assign pressure   = s_axis_tdata[PW-1:0];
    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign armed_now  = armed_seen_reg | s_axis_tuser[0];
    assign is_collect = armed_now && !calibrated_reg && (count_reg < SAMPLES_C);
    assign is_finish  = armed_now && !calibrated_reg && !(count_reg < SAMPLES_C);

    // Slew limit around the last output, then saturate
    always_comb
    begin
        raw = $signed({3'b0, baseline_reg}) - $signed({3'b0, pressure});
        lo  = $signed({{2{last_reg[OW-1]}}, last_reg}) - $signed({10'b0, gate_step_reg});
        hi  = $signed({{2{last_reg[OW-1]}}, last_reg}) + $signed({10'b0, gate_step_reg});
        if (raw < lo)
        begin
            clamped = lo;
        end
        else if (raw > hi)
        begin
            clamped = hi;
        end
        else
        begin
            clamped = raw;
        end
        if (clamped > OUT_MAX)
        begin
            gated = OUT_MAX[OW-1:0];
        end
        else if (clamped < OUT_MIN)
        begin
            gated = OUT_MIN[OW-1:0];
        end
        else
        begin
            gated = clamped[OW-1:0];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bbcg_pkg::T_IDLE:  if (in_fire && is_finish) state_next = bbcg_pkg::T_CALIB;
            bbcg_pkg::T_CALIB: if (cal_status.done) state_next = bbcg_pkg::T_IDLE;
            default:           state_next = bbcg_pkg::T_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        cal_start     = 1'b0;
        unique case (state_reg)
            bbcg_pkg::T_IDLE:
            begin
                s_axis_tready = !res_valid_reg;
                cal_start     = in_fire && is_finish;
            end
            bbcg_pkg::T_CALIB:
            begin
                s_axis_tready = 1'b0;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    assign out_load      = res_valid_reg && (!out_valid_reg || m_axis_tready);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_phase_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bbcg_pkg::T_IDLE;
            gate_step_reg  <= bbcg_pkg::GATE_STEP_RST;
            armed_seen_reg <= 1'b0;
            calibrated_reg <= 1'b0;
            count_reg      <= '0;
            sum_reg        <= '0;
            baseline_reg   <= '0;
            last_reg       <= '0;
            res_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                gate_step_reg <= cfg_wdata;
            end
            if (in_fire)
            begin
                armed_seen_reg <= armed_now;
                if (is_collect)
                begin
                    count_reg     <= count_reg + 1'b1;
                    sum_reg       <= sum_reg + SUM_W'(pressure);
                    last_reg      <= '0;
                    res_valid_reg <= 1'b1;
                end
                else if (!is_finish)
                begin
                    last_reg      <= gated;
                    res_valid_reg <= 1'b1;
                end
            end
            // Finish calibration: keep the mean, accept or restart collection
            if (state_reg == bbcg_pkg::T_CALIB && cal_status.done)
            begin
                baseline_reg  <= cal_status.mean;
                res_valid_reg <= 1'b1;
                if (cal_status.clean)
                begin
                    calibrated_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= '0;
                    sum_reg   <= '0;
                end
            end
            if (out_load)
            begin
                res_valid_reg <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload and running extremes
    always_ff @(posedge clk)
    begin
        if (in_fire && is_collect)
        begin
            res_data_reg  <= '0;
            res_phase_reg <= bbcg_pkg::PH_COLLECT;
            if (count_reg == '0 || pressure < min_reg)
            begin
                min_reg <= pressure;
            end
            if (count_reg == '0 || pressure > max_reg)
            begin
                max_reg <= pressure;
            end
        end
        else if (in_fire && !is_finish)
        begin
            res_data_reg  <= gated;
            res_phase_reg <= bbcg_pkg::PH_GATE;
        end
        else if (state_reg == bbcg_pkg::T_CALIB && cal_status.done)
        begin
            res_data_reg  <= last_reg;
            res_phase_reg <= cal_status.clean ? bbcg_pkg::PH_ACCEPT : bbcg_pkg::PH_REJECT;
        end
        if (out_load)
        begin
            out_data_reg  <= res_data_reg;
            out_phase_reg <= res_phase_reg;
        end
    end

    bbcg_ram #(
        .WIDTH (PW),
        .DEPTH (SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (in_fire && is_collect),
        .waddr (count_reg[IW-1:0]),
        .wdata (pressure),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bbcg_calib #(
        .SAMPLES (SAMPLES)
    ) u_calib (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cal_start),
        .sum     (sum_reg),
        .min_val (min_reg),
        .max_val (max_reg),
        .raddr   (ram_raddr),
        .rdata   (ram_rdata),
        .status  (cal_status)
    );

endmodule
`default_nettype wire

// ===== design/bbcg_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module bbcg_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    logic accepted_reg;

    // Remember an accepted calibration beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accepted_reg <= 1'b0;
        end
        else if (m_axis_tvalid && m_axis_tready && m_axis_tuser == bbcg_pkg::PH_ACCEPT)
        begin
            accepted_reg <= 1'b1;
        end
    end

    // A stalled beat holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // Collection and calibration beats carry zero
    `ASSERT_IMPL(a_nongate_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser != bbcg_pkg::PH_GATE, m_axis_tdata == 24'd0)

    // After an accepted calibration only gating beats follow
    `ASSERT_IMPL(a_calib_final, clk, rst_n, m_axis_tvalid && accepted_reg, m_axis_tuser == bbcg_pkg::PH_GATE)

endmodule

bind baro_baseline_calibrate_gate bbcg_checker u_bbcg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
